// ===== src/dbc_pkg.sv =====
`default_nettype none
package dbc_pkg;

   // byte codes the canonicalizer looks at
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_HT = 8'h09;
   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;

   // depth of the command queue between front and back
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // one command for the back end: a collapsed stream byte or a body end
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } cmd_type;

   // back end sequencer
   typedef enum logic [0:0] {
      BK_RUN,
      BK_END_LF
   } back_state_type;

endpackage
`default_nettype wire

// ===== src/dbc_front.sv =====
`default_nettype none
module dbc_front
   import dbc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       body_mode,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       req_tlast,
   output logic            cmd_push,
   output cmd_type         cmd_out,
   input  wire logic       cmd_full
);

   cmd_type    pend_ff [0:2];
   cmd_type    pend_in [0:2];
   cmd_type    list    [0:2];
   logic [1:0] pend_cnt_ff, pend_cnt_in;
   logic [1:0] list_cnt;
   logic       open_ff, open_in, open_next;
   logic       accept;
   logic       is_sp_ht, is_cont, is_cr;

   // byte classes
   assign is_sp_ht = (req_tdata == CH_SP) || (req_tdata == CH_HT);
   assign is_cont  = is_sp_ht || (req_tdata == CH_LF) || (req_tdata == CH_VT)
                     || (req_tdata == CH_FF);
   assign is_cr    = (req_tdata == CH_CR);

   // hand pending commands to the queue, oldest first
   assign cmd_push   = (pend_cnt_ff != 2'd0) && !cmd_full;
   assign cmd_out    = pend_ff[0];
   assign req_tready = (pend_cnt_ff == 2'd0) || ((pend_cnt_ff == 2'd1) && cmd_push);
   assign accept     = req_tvalid && req_tready;

   // whitespace collapsing: build the command list for one input byte
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         list[i] = '0;
      end
      list_cnt  = 2'd0;
      open_next = open_ff;
      if (body_mode) begin
         if (open_ff) begin
            if (!is_cont) begin
               open_next = 1'b0;
               if (is_cr) begin
                  list[0]  = '{is_end: 1'b0, data: req_tdata};
                  list_cnt = 2'd1;
               end else begin
                  list[0]  = '{is_end: 1'b0, data: CH_SP};
                  list[1]  = '{is_end: 1'b0, data: req_tdata};
                  list_cnt = 2'd2;
               end
            end
         end else if (is_sp_ht) begin
            open_next = 1'b1;
         end else begin
            list[0]  = '{is_end: 1'b0, data: req_tdata};
            list_cnt = 2'd1;
         end
         // a run still open at the body end yields one space
         if (req_tlast && open_next) begin
            list[list_cnt] = '{is_end: 1'b0, data: CH_SP};
            list_cnt       = list_cnt + 2'd1;
            open_next      = 1'b0;
         end
      end else begin
         list[0]   = '{is_end: 1'b0, data: req_tdata};
         list_cnt  = 2'd1;
         open_next = 1'b0;
      end
      if (req_tlast) begin
         list[list_cnt] = '{is_end: 1'b1, data: CH_CR};
         list_cnt       = list_cnt + 2'd1;
         open_next      = 1'b0;
      end
   end

   // next pending list: load on accept, else shift on each transfer to the queue
   always_comb begin
      pend_in     = pend_ff;
      pend_cnt_in = pend_cnt_ff;
      open_in     = open_ff;
      if (accept) begin
         pend_in     = list;
         pend_cnt_in = list_cnt;
         open_in     = open_next;
      end else if (cmd_push) begin
         pend_in[0]  = pend_ff[1];
         pend_in[1]  = pend_ff[2];
         pend_cnt_in = pend_cnt_ff - 2'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= 2'd0;
         open_ff     <= 1'b0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
         open_ff     <= open_in;
      end
   end

   // pending command payload
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule
`default_nettype wire

// ===== src/dbc_cmd_fifo.sv =====
`default_nettype none
module dbc_cmd_fifo
   import dbc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   output logic      full,
   input  wire logic pop,
   output cmd_type   head,
   output logic      empty
);

   cmd_type                mem_ff [0:CMD_DEPTH-1];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // fill level stays within the queue depth
   a_fifo_level: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CMD_CNT_W'(CMD_DEPTH))
      else $error("command queue level out of range");

endmodule
`default_nettype wire

// ===== src/dbc_back.sv =====
`default_nettype none
module dbc_back
   import dbc_pkg::*;
#(
   parameter int MAX_HELD_BREAKS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  cmd_type         head,
   input  wire logic       empty,
   output logic            pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast,
   output logic            rsp_tuser
);

   localparam int PTR_W = (MAX_HELD_BREAKS > 1) ? $clog2(MAX_HELD_BREAKS) : 1;
   localparam int CNT_W = $clog2(MAX_HELD_BREAKS + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_HELD_BREAKS - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_HELD_BREAKS);

   back_state_type     state_ff, state_in;
   logic               held_ff [0:MAX_HELD_BREAKS-1];
   logic               oldest_ff;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               first_done_ff, first_done_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff;
   logic               out_last_ff, out_ovf_ff;

   logic               out_free;
   logic               emit, emit_last, emit_ovf;
   logic [7:0]         emit_byte;
   logic               hold_push, hold_pop, hold_clear;
   logic               first_set, first_clr;
   logic               is_brk;
   logic [7:0]         oldest_byte;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign is_brk      = (head.data == CH_CR) || (head.data == CH_LF);
   assign oldest_byte = oldest_ff ? CH_LF : CH_CR;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_RUN: begin
            if (!empty && head.is_end && out_free) begin
               state_in = BK_END_LF;
            end
         end
         BK_END_LF: begin
            if (out_free) begin
               state_in = BK_RUN;
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   // actions: release, hold or emit one byte a cycle while the output register is free
   always_comb begin
      pop        = 1'b0;
      emit       = 1'b0;
      emit_byte  = head.data;
      emit_last  = 1'b0;
      emit_ovf   = 1'b0;
      hold_push  = 1'b0;
      hold_pop   = 1'b0;
      hold_clear = 1'b0;
      first_set  = 1'b0;
      first_clr  = 1'b0;
      unique case (state_ff)
         BK_RUN: begin
            if (!empty) begin
               if (head.is_end) begin
                  // body end: drop held breaks, start the closing CRLF
                  if (out_free) begin
                     emit       = 1'b1;
                     emit_byte  = CH_CR;
                     hold_clear = 1'b1;
                     first_clr  = 1'b1;
                  end
               end else if (!first_done_ff) begin
                  // first byte of the stream goes out at once
                  if (out_free) begin
                     emit      = 1'b1;
                     pop       = 1'b1;
                     first_set = 1'b1;
                  end
               end else if (is_brk) begin
                  if (cnt_ff == CNT_FULL) begin
                     // store full: release the oldest break flagged
                     if (out_free) begin
                        emit      = 1'b1;
                        emit_byte = oldest_byte;
                        emit_ovf  = 1'b1;
                        hold_pop  = 1'b1;
                        hold_push = 1'b1;
                        pop       = 1'b1;
                     end
                  end else begin
                     hold_push = 1'b1;
                     pop       = 1'b1;
                  end
               end else if (cnt_ff != '0) begin
                  // content byte: drain held breaks first
                  if (out_free) begin
                     emit      = 1'b1;
                     emit_byte = oldest_byte;
                     hold_pop  = 1'b1;
                  end
               end else if (out_free) begin
                  emit = 1'b1;
                  pop  = 1'b1;
               end
            end
         end
         BK_END_LF: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = CH_LF;
               emit_last = 1'b1;
               pop       = 1'b1;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // hold store pointers, level and first byte flag
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (hold_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (hold_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (hold_push && !hold_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (hold_pop && !hold_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
      if (hold_clear) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         cnt_in    = '0;
      end
      first_done_in = first_done_ff;
      if (first_set) begin
         first_done_in = 1'b1;
      end else if (first_clr) begin
         first_done_in = 1'b0;
      end
      out_valid_in = emit || (out_valid_ff && !rsp_tready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_RUN;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         cnt_ff        <= '0;
         first_done_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         cnt_ff        <= cnt_in;
         first_done_ff <= first_done_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // held break store (1 = LF, 0 = CR), registered oldest entry and output register
   always_ff @(posedge clock) begin
      if (hold_push) begin
         held_ff[wr_ptr_ff] <= (head.data == CH_LF);
      end
      // oldest entry follows the next read pointer, bypassing a write to it
      if (hold_push && (wr_ptr_ff == rd_ptr_in)) begin
         oldest_ff <= (head.data == CH_LF);
      end else begin
         oldest_ff <= held_ff[rd_ptr_in];
      end
      if (emit) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= emit_last;
         out_ovf_ff  <= emit_ovf;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

   // hold level never exceeds the store size
   a_hold_level: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("hold store level out of range");

   // an early release only happens with a full store
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      emit && emit_ovf |-> cnt_ff == CNT_FULL)
      else $error("overflow release without full store");

   // the final LF closes the body with an empty store
   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      emit && emit_last |-> state_ff == BK_END_LF && cnt_ff == '0 && !first_done_ff)
      else $error("final byte emitted out of sequence");

endmodule
`default_nettype wire

// ===== src/dkim_body_canonicalizer_core.sv =====
`default_nettype none
// Body canonicalizer for DKIM signing: takes the raw body one byte per transfer
// (tlast on the final byte) and produces the canonical body, ending in CRLF with
// tlast on the LF. csr_data bit 0 selects simple (0) or relaxed (1, reset value)
// canonicalization, written by the user only between bodies; the block does not
// enforce this. A front end collapses whitespace runs and turns each byte into
// zero to three commands; a four entry queue feeds a back end that holds trailing
// CR/LF bytes in a store of MAX_HELD_BREAKS entries and emits one output byte per
// cycle unless rsp_tready stalls it. A byte that makes one command or none is
// taken every cycle unless the queue is full; one with more holds the input
// until all are queued. Held breaks go out when a later content byte releases
// them; a break that finds the store full sends the oldest one with tuser set.
module dkim_body_canonicalizer_core
   import dbc_pkg::*;
#(
   parameter int MAX_HELD_BREAKS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration write
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_data,     // body_mode
   // raw body bytes
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // in_byte
   input  wire logic       req_tlast,
   // canonical body bytes
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // out_byte
   output logic            rsp_tlast,
   output logic            rsp_tuser     // hold_overflow
);

   logic    body_mode_ff, body_mode_in;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_in_q, cmd_head;

   // mode register
   assign csr_ready    = 1'b1;
   assign body_mode_in = (csr_valid && csr_ready) ? csr_data : body_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_mode_ff <= 1'b1;
      end else begin
         body_mode_ff <= body_mode_in;
      end
   end

   // input classification and whitespace collapsing
   dbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .body_mode  (body_mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd_push   (cmd_push),
      .cmd_out    (cmd_in_q),
      .cmd_full   (cmd_full)
   );

   // command queue
   dbc_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in_q),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .head     (cmd_head),
      .empty    (cmd_empty)
   );

   // line break holding and output
   dbc_back #(
      .MAX_HELD_BREAKS (MAX_HELD_BREAKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (cmd_head),
      .empty      (cmd_empty),
      .pop        (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== sim/dkim_body_canonicalizer_core_tb.sv =====
`timescale 1ns / 100ps

module dkim_body_canonicalizer_core_tb;
   import dbc_pkg::*;

   localparam int HOLD_DEPTH      = 32;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int LONG_HOLD       = 300;
   localparam int SETTLE          = 10;
   localparam int CYCLE_LIMIT     = 200000;

   localparam logic MODE_SIMPLE  = 1'b0;
   localparam logic MODE_RELAXED = 1'b1;

   // {last, byte} forms used for the hand-written expectations
   localparam logic [8:0] E_NONE   = 9'h000;
   localparam logic [8:0] E_CR     = {1'b0, CH_CR};
   localparam logic [8:0] E_LF     = {1'b0, CH_LF};
   localparam logic [8:0] E_LF_END = {1'b1, CH_LF};
   localparam logic [8:0] E_SP     = {1'b0, CH_SP};

   typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic       mode;      // body mode for a csr row
      logic [7:0] data;
      logic       last;
      logic [5:0] reps;
      logic       typed;     // 1: expectation typed in below, 0: predicted
      logic [1:0] n_typed;
      logic [8:0] t0;
      logic [8:0] t1;
      logic [8:0] t2;
   } script_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       ovf;
   } canon_byte_type;

   // directed stimulus, starting in relaxed mode straight after reset
   localparam int SCRIPT_LEN = 26;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // first byte goes straight out, even a CR
      '{ROW_BYTE, 1'b0, CH_CR, 1'b0, 6'd1, 1'b1, 2'd1, E_CR, E_NONE, E_NONE},
      // space run closed by content gives one SP
      '{ROW_BYTE, 1'b0, CH_SP, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_HT, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, 8'h61, 1'b0, 6'd1, 1'b1, 2'd2, E_SP, {1'b0, 8'h61}, E_NONE},
      // held breaks released by a content byte
      '{ROW_BYTE, 1'b0, CH_CR, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_LF, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, 8'hFF, 1'b0, 6'd1, 1'b1, 2'd3, E_CR, E_LF, {1'b0, 8'hFF}},
      // run over VT and FF, dropped at CR
      '{ROW_BYTE, 1'b0, CH_SP, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_VT, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_FF, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_CR, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_LF, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, 8'h00, 1'b1, 6'd1, 1'b0, 2'd0, E_NONE, E_NONE, E_NONE},
      // simple mode: spaces pass, trailing breaks dropped at body end
      '{ROW_CFG, MODE_SIMPLE, 8'h00, 1'b0, 6'd0, 1'b0, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_SP, 1'b0, 6'd1, 1'b1, 2'd1, E_SP, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_SP, 1'b0, 6'd1, 1'b1, 2'd1, E_SP, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_CR, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_LF, 1'b0, 6'd1, 1'b1, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_LF, 1'b1, 6'd1, 1'b1, 2'd2, E_CR, E_LF_END, E_NONE},
      // relaxed again: pending run at body end, one-byte body with a high byte
      '{ROW_CFG, MODE_RELAXED, 8'h00, 1'b0, 6'd0, 1'b0, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, 8'h62, 1'b0, 6'd1, 1'b1, 2'd1, {1'b0, 8'h62}, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_SP, 1'b1, 6'd1, 1'b1, 2'd3, E_SP, E_CR, E_LF_END},
      '{ROW_BYTE, 1'b0, 8'h80, 1'b1, 6'd1, 1'b1, 2'd3, {1'b0, 8'h80}, E_CR, E_LF_END},
      // hold store overrun, then everything released by content
      '{ROW_BYTE, 1'b0, 8'h63, 1'b0, 6'd1, 1'b1, 2'd1, {1'b0, 8'h63}, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, CH_LF, 1'b0, 6'd34, 1'b0, 2'd0, E_NONE, E_NONE, E_NONE},
      '{ROW_BYTE, 1'b0, 8'h7F, 1'b1, 6'd1, 1'b0, 2'd0, E_NONE, E_NONE, E_NONE}
   };

   localparam logic PHASE_MODE [4] = '{MODE_SIMPLE, MODE_RELAXED, MODE_SIMPLE, MODE_RELAXED};
   localparam int   IDLE_PCT   [4] = '{0, 46, 0, 37};
   localparam int   STALL_PCT  [4] = '{0, 0, 46, 37};

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic       csr_data   = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   // predictor state
   logic                  relaxed_mode = MODE_RELAXED;
   logic [HOLD_DEPTH-1:0] held_lf      = '0;
   int                    held_count_m = 0;
   logic                  space_open   = 1'b0;
   logic                  first_sent   = 1'b0;
   canon_byte_type        step_bytes[$];
   canon_byte_type        canon_due[$];

   // run bookkeeping
   int          cycle_count   = 0;
   int          mismatches    = 0;
   int          bytes_sent    = 0;
   int          bodies_sent   = 0;
   int          results_seen  = 0;
   int          early_release = 0;
   int          idle_pct      = 0;
   int          stall_pct     = 0;
   logic        hold_kick     = 1'b0;
   logic        hold_started  = 1'b0;
   int          hold_left     = 0;
   canon_byte_type got_due;

   dkim_body_canonicalizer_core #(
      .MAX_HELD_BREAKS(HOLD_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
                  canon_due.size());
         $display("dkim_body_canonicalizer_core_tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   function automatic void push_step_byte(input logic [7:0] d, input logic l, input logic o);
      canon_byte_type e;
      e.data     = d;
      e.last     = l;
      e.ovf      = o;
      step_bytes = {step_bytes, e};
   endfunction

   // append one expected byte to the due list
   function automatic void queue_due(input canon_byte_type e);
      canon_due = {canon_due, e};
   endfunction

   // typed {last, byte} expectation, never an early release
   function automatic void queue_typed(input logic [8:0] t);
      canon_byte_type e;
      e.data = t[7:0];
      e.last = t[8];
      e.ovf  = 1'b0;
      queue_due(e);
   endfunction

   // trailing break holder on the collapsed stream
   function automatic void pass_through_holder(input logic [7:0] c);
      int i;
      if (!first_sent) begin
         first_sent = 1'b1;
         push_step_byte(c, 1'b0, 1'b0);
      end else if (c == CH_CR || c == CH_LF) begin
         if (held_count_m == HOLD_DEPTH) begin
            push_step_byte(held_lf[0] ? CH_LF : CH_CR, 1'b0, 1'b1);
            held_lf      = held_lf >> 1;
            held_count_m = HOLD_DEPTH - 1;
         end
         held_lf[held_count_m] = (c == CH_LF);
         held_count_m++;
      end else begin
         for (i = 0; i < held_count_m; i++)
            push_step_byte(held_lf[i] ? CH_LF : CH_CR, 1'b0, 1'b0);
         held_count_m = 0;
         push_step_byte(c, 1'b0, 1'b0);
      end
   endfunction

   // canonical bytes caused by one body byte, left in step_bytes
   function automatic void canon_step(input logic [7:0] b, input logic lst);
      logic run_goes_on;
      step_bytes.delete();
      run_goes_on = (b == CH_SP || b == CH_HT || b == CH_LF || b == CH_VT || b == CH_FF);
      if (relaxed_mode) begin
         if (space_open) begin
            if (b == CH_CR) begin
               space_open = 1'b0;
               pass_through_holder(b);
            end else if (!run_goes_on) begin
               space_open = 1'b0;
               pass_through_holder(CH_SP);
               pass_through_holder(b);
            end
         end else if (b == CH_SP || b == CH_HT) begin
            space_open = 1'b1;
         end else begin
            pass_through_holder(b);
         end
         if (lst && space_open) begin
            space_open = 1'b0;
            pass_through_holder(CH_SP);
         end
      end else begin
         space_open = 1'b0;
         pass_through_holder(b);
      end
      if (lst) begin
         held_count_m = 0;
         space_open   = 1'b0;
         first_sent   = 1'b0;
         push_step_byte(CH_CR, 1'b0, 1'b0);
         push_step_byte(CH_LF, 1'b1, 1'b0);
      end
   endfunction

   // one body byte transfer, with random gaps in front
   task automatic send_byte(input logic [7:0] b, input logic lst, input logic from_model);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      canon_step(b, lst);
      if (from_model)
         foreach (step_bytes[i]) queue_due(step_bytes[i]);
      bytes_sent++;
      if (lst) bodies_sent++;
   endtask

   // stop offering and wait until every due byte is out
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (canon_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_body_mode(input logic m);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      relaxed_mode = m;
   endtask

   // one body of mixed text, whitespace and line breaks
   task automatic send_random_body(inout int sent);
      logic [7:0] body[$];
      int         len;
      int         pick;
      int         k;
      len = $urandom_range(1, 20);
      while (body.size() < len) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            // burst of 30 to 40 breaks, which overruns the hold store when longer than HOLD_DEPTH
            repeat ($urandom_range(30, 40))
               body = {body, ($urandom_range(1) ? CH_LF : CH_CR)};
         end else if (pick < 20) begin
            body = {body, ($urandom_range(1) ? CH_SP : CH_HT)};
         end else if (pick < 30) begin
            body = {body, (pick < 24 ? CH_VT : (pick < 27 ? CH_FF : CH_LF))};
         end else if (pick < 45) begin
            body = {body, CH_CR, CH_LF};
         end else if (pick < 55) begin
            body = {body, ($urandom_range(1) ? CH_LF : CH_CR)};
         end else if (pick < 85) begin
            body = {body, 8'($urandom_range(33, 126))};
         end else begin
            body = {body, 8'($urandom_range(255))};
         end
      end
      for (k = 0; k < body.size(); k++) begin
         send_byte(body[k], k == body.size() - 1, 1'b1);
         sent++;
      end
   endtask

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_kick && !hold_started) begin
         hold_started <= 1'b1;
         hold_left    <= LONG_HOLD;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) early_release++;
         if (canon_due.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b overflow %0b",
                                      rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            got_due = canon_due.pop_front();
            if (rsp_tdata !== got_due.data)
               report_mismatch($sformatf("byte %02h, wanted %02h", rsp_tdata, got_due.data));
            if (rsp_tlast !== got_due.last)
               report_mismatch($sformatf("tlast %0b, wanted %0b on byte %02h",
                                         rsp_tlast, got_due.last, got_due.data));
            if (rsp_tuser !== got_due.ovf)
               report_mismatch($sformatf("overflow flag %0b, wanted %0b on byte %02h",
                                         rsp_tuser, got_due.ovf, got_due.data));
         end
      end
   end

   initial begin
      int   phase_sent;
      logic paused;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         if (SCRIPT[r].kind == ROW_CFG) begin
            wait_for_results();
            write_body_mode(SCRIPT[r].mode);
         end else begin
            for (int k = 0; k < SCRIPT[r].reps; k++)
               send_byte(SCRIPT[r].data, SCRIPT[r].last, !SCRIPT[r].typed);
            if (SCRIPT[r].typed && SCRIPT[r].n_typed > 0)
               queue_typed(SCRIPT[r].t0);
            if (SCRIPT[r].typed && SCRIPT[r].n_typed > 1)
               queue_typed(SCRIPT[r].t1);
            if (SCRIPT[r].typed && SCRIPT[r].n_typed > 2)
               queue_typed(SCRIPT[r].t2);
         end
      end

      // random bodies in four handshake phases
      for (int p = 0; p < 4; p++) begin
         wait_for_results();
         write_body_mode(PHASE_MODE[p]);
         idle_pct = IDLE_PCT[p];
         stall_pct <= STALL_PCT[p];
         if (p == 2) hold_kick <= 1'b1;
         phase_sent = 0;
         paused     = 1'b0;
         while (phase_sent < ITEMS_PER_PHASE) begin
            // sender pause until the block has emptied
            if (p == 1 && !paused && phase_sent >= ITEMS_PER_PHASE / 2) begin
               paused = 1'b1;
               wait_for_results();
            end
            send_random_body(phase_sent);
         end
      end

      wait_for_results();
      $display("covered %0d body bytes in %0d bodies, simple and relaxed modes, four flow phases",
               bytes_sent, bodies_sent);
      $display("checked %0d canonical bytes, %0d released early from a full hold store",
               results_seen, early_release);
      if (mismatches == 0)
         $display("dkim_body_canonicalizer_core_tb OK");
      else
         $display("dkim_body_canonicalizer_core_tb NOT OK");
      $finish;
   end

endmodule
